// File: src/lseg_pkg.sv
// Package for the LED strip effect generator.
// Holds the effect mode codes, write kinds, register indexes, field widths
// and the hue ramp function. No dependencies.
package lseg_pkg;

  // Configuration port widths
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_MODE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_COLOR    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD_MS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEDS        = 4'd3;

  // Register reset values
  localparam logic [1:0]  RST_EFFECT_MODE     = 2'd0;
  localparam logic [23:0] RST_EFFECT_COLOR    = 24'h000040;
  localparam logic [15:0] RST_FRAME_PERIOD_MS = 16'd16;
  localparam logic [8:0]  RST_NUM_LEDS        = 9'd256;

  // Hue sweep limits
  localparam logic [8:0] HUE_TOP = 9'd360;

  // Effect modes; the unused code behaves as the beat scanner
  typedef enum logic [1:0] {
    MODE_BEAT    = 2'd0,
    MODE_RAINBOW = 2'd1,
    MODE_SOLID   = 2'd2
  } mode_t;

  // Kinds of strip write carried by a result
  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_PIXEL = 2'd1,
    WR_FILL  = 2'd2
  } write_kind_t;

  // One RGB color
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Linear ramp over a 60-degree sector: round(d*4.25-0.01) as (d*17+1)>>2
  function automatic logic [7:0] hue_ramp(input logic [8:0] d);
    logic [13:0] prod;
    begin
      prod     = {5'd0, d} * 14'd17 + 14'd1;
      hue_ramp = prod[9:2];
    end
  endfunction

endpackage

// File: src/lseg_in_if.sv
// Input channel interface: one millisecond time stamp per transaction.
// Depends on nothing.
interface lseg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

// File: src/lseg_out_if.sv
// Result channel interface: one strip write description per transaction.
// Depends on nothing.
interface lseg_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] write_kind;
  logic [7:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output write_kind, output pixel_index,
                  output red, output green, output blue, input ready);
  modport sink   (input valid, input write_kind, input pixel_index,
                  input red, input green, input blue, output ready);
endinterface

// File: src/lseg_cfg_if.sv
// Configuration write channel interface: register index plus write data.
// Depends on lseg_pkg for the field widths.
interface lseg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lseg_pkg::CFG_IDX_W-1:0]   index;
  logic [lseg_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/lseg_hue.sv
// Hue angle to RGB conversion with six linear 60-degree ramps.
// Depends on lseg_pkg (rgb_t, hue_ramp).
module lseg_hue (
  input  logic [8:0]     angle,
  output lseg_pkg::rgb_t color
);

  logic [8:0] ramp_d;

  // Pick the sector and the ramp distance for it
  always_comb begin
    ramp_d = 9'd0;
    color  = '0;
    if (angle < 9'd60) begin
      ramp_d      = angle;
      color.red   = 8'hFF;
      color.green = lseg_pkg::hue_ramp(ramp_d);
    end else if (angle < 9'd120) begin
      ramp_d      = 9'd120 - angle;
      color.red   = lseg_pkg::hue_ramp(ramp_d);
      color.green = 8'hFF;
    end else if (angle < 9'd180) begin
      ramp_d      = angle - 9'd120;
      color.green = 8'hFF;
      color.blue  = lseg_pkg::hue_ramp(ramp_d);
    end else if (angle < 9'd240) begin
      ramp_d      = 9'd240 - angle;
      color.green = lseg_pkg::hue_ramp(ramp_d);
      color.blue  = 8'hFF;
    end else if (angle < 9'd300) begin
      ramp_d      = angle - 9'd240;
      color.red   = lseg_pkg::hue_ramp(ramp_d);
      color.blue  = 8'hFF;
    end else begin
      // distance wraps at 9 bits past the top of the sweep
      ramp_d      = lseg_pkg::HUE_TOP - angle;
      color.red   = 8'hFF;
      color.blue  = lseg_pkg::hue_ramp(ramp_d);
    end
  end

endmodule

// File: src/led_strip_effect_generator.sv
// LED strip effect generator top level.
// Depends on lseg_pkg, lseg_in_if, lseg_out_if, lseg_cfg_if and lseg_hue.
//
// Takes one millisecond time stamp per transaction and returns exactly one
// result per time stamp describing the strip write for it: nothing, one pixel
// (beat scanner) or a whole-strip fill (rainbow sweep, solid fill). A frame is
// drawn only when now_ms is strictly above last draw time plus frame_period_ms
// (32-bit wrapping sum). The effect state and the output register both update on
// the edge that accepts a time stamp, so a new time stamp is taken every cycle
// while the output side keeps up. The configuration port is always ready;
// writing effect_mode clears the frame index. Writes to unknown indexes are
// dropped. MAX_LEDS caps the strip length together with the 256-LED limit.
module led_strip_effect_generator #(
  parameter int MAX_LEDS = 256
) (
  input logic          clk,
  input logic          rst_n,
  lseg_in_if.sink      in_chan,
  lseg_out_if.source   out_chan,
  lseg_cfg_if.sink     cfg_chan
);

  localparam int         CAP_INT = (MAX_LEDS < 256) ? MAX_LEDS : 256;
  localparam logic [8:0] LEN_CAP = 9'(CAP_INT);

  // Configuration registers
  logic [1:0]  effect_mode_r;
  logic [23:0] effect_color_r;
  logic [15:0] frame_period_ms_r;
  logic [8:0]  num_leds_r;

  // Effect state
  logic [31:0] last_draw_ms_r, last_draw_ms_nxt;
  logic [7:0]  frame_index_r, frame_index_nxt;
  logic        beat_reverse_r, beat_reverse_nxt;
  logic [8:0]  hue_angle_r, hue_angle_nxt;
  logic        hue_reverse_r, hue_reverse_nxt;

  // Output register
  logic        out_valid_r;
  logic [1:0]  write_kind_r, write_kind_nxt;
  logic [7:0]  pixel_index_r, pixel_index_nxt;
  lseg_pkg::rgb_t color_r, color_nxt;

  logic           in_fire;
  logic           mode_wr;
  logic           due;
  logic [31:0]    due_ms;
  logic [8:0]     strip_len;
  logic [7:0]     last_pix;
  logic [7:0]     beat_pos;
  logic [8:0]     hue_step;
  lseg_pkg::rgb_t hue_color;
  lseg_pkg::rgb_t cfg_color;

  assign cfg_chan.ready = 1'b1;
  assign mode_wr        = cfg_chan.valid && (cfg_chan.index == lseg_pkg::CFG_EFFECT_MODE);

  // Input is taken whenever the output register is empty or draining
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign due_ms    = {16'd0, frame_period_ms_r} + last_draw_ms_r;
  assign due       = in_chan.now_ms > due_ms;
  assign cfg_color = effect_color_r;

  // Strip length in use: capped, zero counts as one
  always_comb begin
    strip_len = (num_leds_r > LEN_CAP) ? LEN_CAP : num_leds_r;
    if (strip_len == 9'd0) begin
      strip_len = 9'd1;
    end
  end
  assign last_pix = 8'(strip_len - 9'd1);
  assign beat_pos = (frame_index_r > last_pix) ? last_pix : frame_index_r;

  lseg_hue u_hue (
    .angle (hue_angle_r),
    .color (hue_color)
  );

  // Next effect state and result for a due frame
  always_comb begin
    last_draw_ms_nxt = last_draw_ms_r;
    frame_index_nxt  = frame_index_r;
    beat_reverse_nxt = beat_reverse_r;
    hue_angle_nxt    = hue_angle_r;
    hue_reverse_nxt  = hue_reverse_r;
    write_kind_nxt   = lseg_pkg::WR_NONE;
    pixel_index_nxt  = 8'd0;
    color_nxt        = '0;
    hue_step         = 9'd0;
    if (due) begin
      last_draw_ms_nxt = in_chan.now_ms;
      case (effect_mode_r)
        lseg_pkg::MODE_RAINBOW: begin
          write_kind_nxt = lseg_pkg::WR_FILL;
          color_nxt      = hue_color;
          if (hue_reverse_r) begin
            hue_step = hue_angle_r - 9'd1;
            if (hue_step == 9'd0) begin
              hue_reverse_nxt = 1'b0;
            end
          end else begin
            hue_step = hue_angle_r + 9'd1;
            if (hue_step >= lseg_pkg::HUE_TOP) begin
              hue_reverse_nxt = 1'b1;
            end
          end
          hue_angle_nxt = hue_step;
        end
        lseg_pkg::MODE_SOLID: begin
          if (frame_index_r == 8'd0) begin
            write_kind_nxt  = lseg_pkg::WR_FILL;
            color_nxt       = cfg_color;
            frame_index_nxt = 8'd1;
          end
        end
        default: begin
          // beat scanner: color on the way up, black on the way down
          write_kind_nxt  = lseg_pkg::WR_PIXEL;
          pixel_index_nxt = beat_pos;
          frame_index_nxt = beat_pos;
          if (!beat_reverse_r) begin
            color_nxt = cfg_color;
            if (beat_pos >= last_pix) begin
              beat_reverse_nxt = 1'b1;
              frame_index_nxt  = last_pix;
            end else begin
              frame_index_nxt = beat_pos + 8'd1;
            end
          end else begin
            if (beat_pos == 8'd0) begin
              beat_reverse_nxt = 1'b0;
            end else begin
              frame_index_nxt = beat_pos - 8'd1;
            end
          end
        end
      endcase
    end
    // a mode write restarts the frame index
    if (mode_wr) begin
      frame_index_nxt = 8'd0;
    end
  end

  // Control state, configuration and effect state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r       <= 1'b0;
      effect_mode_r     <= lseg_pkg::RST_EFFECT_MODE;
      effect_color_r    <= lseg_pkg::RST_EFFECT_COLOR;
      frame_period_ms_r <= lseg_pkg::RST_FRAME_PERIOD_MS;
      num_leds_r        <= lseg_pkg::RST_NUM_LEDS;
      last_draw_ms_r    <= 32'd0;
      frame_index_r     <= 8'd0;
      beat_reverse_r    <= 1'b0;
      hue_angle_r       <= 9'd0;
      hue_reverse_r     <= 1'b0;
    end else begin
      if (in_fire) begin
        out_valid_r    <= 1'b1;
        last_draw_ms_r <= last_draw_ms_nxt;
        beat_reverse_r <= beat_reverse_nxt;
        hue_angle_r    <= hue_angle_nxt;
        hue_reverse_r  <= hue_reverse_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      // frame index: effect step or mode write
      if (in_fire || mode_wr) begin
        frame_index_r <= frame_index_nxt;
      end
      // register writes
      if (cfg_chan.valid) begin
        case (cfg_chan.index)
          lseg_pkg::CFG_EFFECT_MODE: begin
            effect_mode_r <= cfg_chan.data[1:0];
          end
          lseg_pkg::CFG_EFFECT_COLOR: begin
            effect_color_r <= cfg_chan.data[23:0];
          end
          lseg_pkg::CFG_FRAME_PERIOD_MS: begin
            frame_period_ms_r <= cfg_chan.data[15:0];
          end
          lseg_pkg::CFG_NUM_LEDS: begin
            num_leds_r <= cfg_chan.data[8:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      write_kind_r  <= write_kind_nxt;
      pixel_index_r <= pixel_index_nxt;
      color_r       <= color_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.write_kind  = write_kind_r;
  assign out_chan.pixel_index = pixel_index_r;
  assign out_chan.red         = color_r.red;
  assign out_chan.green       = color_r.green;
  assign out_chan.blue        = color_r.blue;

endmodule

// File: tb/sv/tb_top.sv
// Testbench for led_strip_effect_generator: time stamps in, strip writes out,
// checked against an in-bench model of the beat, rainbow and solid effects.
// Depends on lseg_pkg, the three lseg channel interfaces and the RTL top level.
module tb_top;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 4;
  localparam int LED_LIMIT     = 256;
  localparam int STRIP_CAP     = 256;
  localparam int SECTOR        = 60;
  localparam int PHASES        = 10;
  localparam int RAINBOW_ITEMS = 120;
  localparam int OTHER_ITEMS   = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RUN_LIMIT     = 2000000;

  // Mode code with no name in the package; the block treats it as beat
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // Register indexes that select nothing
  localparam logic [lseg_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 4'd4;
  localparam logic [lseg_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 4'd15;

  typedef struct packed {
    lseg_pkg::write_kind_t kind;
    logic [7:0]            pixel;
    lseg_pkg::rgb_t        color;
  } strip_write_t;

  logic clk = 1'b0;
  logic rst_n;

  lseg_in_if  in_bus ();
  lseg_out_if out_bus ();
  lseg_cfg_if cfg_bus ();

  led_strip_effect_generator #(.MAX_LEDS(LED_LIMIT)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  always #CLK_HALF clk = ~clk;

  // Effect model: registers and frame state
  logic [1:0]  mode_reg;
  logic [23:0] color_reg;
  logic [15:0] period_reg;
  logic [8:0]  leds_reg;
  logic [31:0] last_draw;
  logic [7:0]  frame_idx;
  logic        beat_back;
  logic [8:0]  hue;
  logic        hue_back;

  strip_write_t pending_writes[$];
  logic [31:0]  stamp_q[$];
  strip_write_t due_write;

  int unsigned src_idle_pct, snk_idle_pct, hold_left, errors;
  // Stimulus-side view of draw timing, used to aim stamps at frame boundaries
  logic [31:0] gen_last;
  logic [15:0] gen_period;

  function automatic logic [7:0] ramp_level(input logic [8:0] span);
    int unsigned scaled;
    scaled = (span * 17 + 1) >> 2;
    return scaled[7:0];
  endfunction

  // Six linear ramps over 60-degree sectors
  function automatic lseg_pkg::rgb_t hue_color(input logic [8:0] angle);
    lseg_pkg::rgb_t c;
    if (angle < SECTOR)
      c = '{8'hFF, ramp_level(angle), 8'h00};
    else if (angle < 2 * SECTOR)
      c = '{ramp_level(9'(2 * SECTOR) - angle), 8'hFF, 8'h00};
    else if (angle < 3 * SECTOR)
      c = '{8'h00, 8'hFF, ramp_level(angle - 9'(2 * SECTOR))};
    else if (angle < 4 * SECTOR)
      c = '{8'h00, ramp_level(9'(4 * SECTOR) - angle), 8'hFF};
    else if (angle < 5 * SECTOR)
      c = '{ramp_level(angle - 9'(4 * SECTOR)), 8'h00, 8'hFF};
    else
      c = '{8'hFF, 8'h00, ramp_level(lseg_pkg::HUE_TOP - angle)};
    return c;
  endfunction

  task automatic apply_reg(input logic [lseg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lseg_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      lseg_pkg::CFG_EFFECT_MODE: begin
        mode_reg  = data[1:0];
        frame_idx = '0;
      end
      lseg_pkg::CFG_EFFECT_COLOR:    color_reg  = data[23:0];
      lseg_pkg::CFG_FRAME_PERIOD_MS: period_reg = data[15:0];
      lseg_pkg::CFG_NUM_LEDS:        leds_reg   = data[8:0];
      default: ;
    endcase
  endtask

  // Strip write for one time stamp; advances the frame state when due
  task automatic draw_frame(input logic [31:0] now_ms, output strip_write_t wr);
    logic [31:0] due_at;
    int unsigned len;
    wr = '0;
    due_at = last_draw + period_reg;
    if (now_ms > due_at) begin
      len = leds_reg;
      if (len > LED_LIMIT) len = LED_LIMIT;
      if (len > STRIP_CAP) len = STRIP_CAP;
      if (len == 0) len = 1;
      case (mode_reg)
        lseg_pkg::MODE_RAINBOW: begin
          wr.kind  = lseg_pkg::WR_FILL;
          wr.color = hue_color(hue);
          if (hue_back) begin
            hue = hue - 9'd1;
            if (hue == '0) hue_back = 1'b0;
          end else begin
            hue = hue + 9'd1;
            if (hue >= lseg_pkg::HUE_TOP) hue_back = 1'b1;
          end
        end
        lseg_pkg::MODE_SOLID: begin
          // filled once per mode write
          if (frame_idx == '0) begin
            wr.kind   = lseg_pkg::WR_FILL;
            wr.color  = color_reg;
            frame_idx = 8'd1;
          end
        end
        default: begin
          // strip may have shrunk under the scan position
          if (frame_idx > len - 1) frame_idx = 8'(len - 1);
          wr.kind  = lseg_pkg::WR_PIXEL;
          wr.pixel = frame_idx;
          if (!beat_back) begin
            wr.color = color_reg;
            if (frame_idx >= len - 1) begin
              beat_back = 1'b1;
              frame_idx = 8'(len - 1);
            end else begin
              frame_idx++;
            end
          end else if (frame_idx == '0) begin
            beat_back = 1'b0;
          end else begin
            frame_idx--;
          end
        end
      endcase
      last_draw = now_ms;
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  // Monitor: checks result transactions, tracks config and input transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      mode_reg   = lseg_pkg::RST_EFFECT_MODE;
      color_reg  = lseg_pkg::RST_EFFECT_COLOR;
      period_reg = lseg_pkg::RST_FRAME_PERIOD_MS;
      leds_reg   = lseg_pkg::RST_NUM_LEDS;
      last_draw  = '0;
      frame_idx  = '0;
      beat_back  = 1'b0;
      hue        = '0;
      hue_back   = 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_writes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, %s %0d pixel %0d rgb %02h%02h%02h",
                   $time, "actual kind", out_bus.write_kind, out_bus.pixel_index,
                   out_bus.red, out_bus.green, out_bus.blue);
        end else begin
          due_write = pending_writes.pop_front();
          check_field("write_kind", due_write.kind, out_bus.write_kind);
          check_field("pixel_index", due_write.pixel, out_bus.pixel_index);
          check_field("red", due_write.color.red, out_bus.red);
          check_field("green", due_write.color.green, out_bus.green);
          check_field("blue", due_write.color.blue, out_bus.blue);
        end
      end
      if (cfg_bus.valid && cfg_bus.ready)
        apply_reg(cfg_bus.index, cfg_bus.data);
      if (in_bus.valid && in_bus.ready) begin
        draw_frame(in_bus.now_ms, due_write);
        pending_writes.push_back(due_write);
      end
    end
  end

  // Driver: offers queued time stamps, idling at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (stamp_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
        in_bus.valid  <= 1'b1;
        in_bus.now_ms <= stamp_q.pop_front();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n)
      out_bus.ready <= 1'b0;
    else if (hold_left != 0)
      out_bus.ready <= 1'b0;
    else
      out_bus.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  task automatic send_stamp(input logic [31:0] t);
    stamp_q.push_back(t);
    if (t > gen_last + gen_period) gen_last = t;
  endtask

  // Mostly stamps just past the frame boundary; some on it, short or random
  function automatic logic [31:0] next_stamp();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 5)       return $urandom;
    else if (pick < 7)  return 32'hFFFF_FFFF - $urandom_range(gen_period, 0);
    else if (pick < 13) return gen_last + gen_period;
    else if (pick < 20) return gen_last + $urandom_range(gen_period, 0);
    else                return gen_last + gen_period + 1 + $urandom_range(3, 0);
  endfunction

  // Low bits carry the value, bits above the register width are noise
  task automatic write_reg(input logic [lseg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value, input int unsigned width);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= ($urandom << width) | value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == lseg_pkg::CFG_FRAME_PERIOD_MS) gen_period = value[15:0];
    @(negedge clk);
  endtask

  // Wait until every offered stamp has its result back; sampled mid-cycle
  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    while ((stamp_q.size() != 0 || in_bus.valid || pending_writes.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_writes.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_writes.size());
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    #(RUN_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int unsigned phase, item, count, k;
    logic [1:0]  pick_mode;
    logic [31:0] pick_value;

    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.now_ms  = '0;
    out_bus.ready  = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = '0;
    cfg_bus.data   = '0;
    errors         = 0;
    hold_left      = 0;
    gen_last       = '0;
    gen_period     = lseg_pkg::RST_FRAME_PERIOD_MS;
    src_idle_pct   = 8;
    snk_idle_pct   = 74;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset defaults: boundary stamps, wrap of the due time at 32 bits
    send_stamp(0);
    send_stamp(16);
    send_stamp(17);
    send_stamp(33);
    send_stamp(34);
    send_stamp(32'hFFFF_FFFF);
    send_stamp(0);
    send_stamp(15);
    send_stamp(16);
    wait_idle();

    // Zero LEDs count as one; scan position clamped back to the end
    write_reg(lseg_pkg::CFG_NUM_LEDS, 0, 9);
    write_reg(lseg_pkg::CFG_EFFECT_COLOR, 24'hFF_FFFF, 24);
    write_reg(lseg_pkg::CFG_FRAME_PERIOD_MS, 0, 16);
    send_stamp(17);
    send_stamp(18);
    send_stamp(18);
    wait_idle();

    // Oversized strip, spare mode as beat, longest period, dead indexes
    write_reg(lseg_pkg::CFG_NUM_LEDS, 9'h1FF, 9);
    write_reg(lseg_pkg::CFG_EFFECT_MODE, MODE_SPARE, 2);
    write_reg(lseg_pkg::CFG_FRAME_PERIOD_MS, 16'hFFFF, 16);
    write_reg(CFG_IDX_SPARE_LO, 32'hFFFF_FFFF, 0);
    write_reg(CFG_IDX_SPARE_HI, 0, 0);
    send_stamp(65555);
    send_stamp(131088);
    send_stamp(131091);
    wait_idle();

    // Solid fill once, then a due frame that writes nothing
    write_reg(lseg_pkg::CFG_EFFECT_MODE, lseg_pkg::MODE_SOLID, 2);
    write_reg(lseg_pkg::CFG_EFFECT_COLOR, 0, 24);
    send_stamp(196627);
    send_stamp(262163);
    wait_idle();

    write_reg(lseg_pkg::CFG_EFFECT_MODE, lseg_pkg::MODE_RAINBOW, 2);
    write_reg(lseg_pkg::CFG_FRAME_PERIOD_MS, 0, 16);
    for (k = 0; k < 4; k++) send_stamp(262164 + k);
    wait_idle();

    // Back to beat: direction flag survives the mode write
    write_reg(lseg_pkg::CFG_EFFECT_MODE, lseg_pkg::MODE_BEAT, 2);
    write_reg(lseg_pkg::CFG_NUM_LEDS, 3, 9);
    for (k = 0; k < 3; k++) send_stamp(262168 + k);

    // Random phases; odd phases sweep the rainbow so the hue turns round
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 4) begin
        src_idle_pct = 74;
        snk_idle_pct = 8;
      end else if (phase == 7) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      wait_idle();

      if (phase % 2 == 1) begin
        write_reg(lseg_pkg::CFG_EFFECT_MODE, lseg_pkg::MODE_RAINBOW, 2);
      end else if ($urandom_range(9, 0) != 0) begin
        case ($urandom_range(2, 0))
          0:       pick_mode = lseg_pkg::MODE_BEAT;
          1:       pick_mode = lseg_pkg::MODE_SOLID;
          default: pick_mode = MODE_SPARE;
        endcase
        write_reg(lseg_pkg::CFG_EFFECT_MODE, pick_mode, 2);
      end
      if ($urandom_range(3, 0) != 0) begin
        case ($urandom_range(4, 0))
          0:       pick_value = 0;
          1:       pick_value = 24'hFF_FFFF;
          default: pick_value = $urandom_range(24'hFF_FFFF, 0);
        endcase
        write_reg(lseg_pkg::CFG_EFFECT_COLOR, pick_value, 24);
      end
      if ($urandom_range(3, 0) != 0) begin
        case ($urandom_range(9, 0))
          0:       pick_value = 0;
          1:       pick_value = 16'hFFFF;
          2, 3:    pick_value = $urandom_range(16'hFFFF, 0);
          default: pick_value = $urandom_range(20, 0);
        endcase
        write_reg(lseg_pkg::CFG_FRAME_PERIOD_MS, pick_value, 16);
      end
      if ($urandom_range(3, 0) != 0) begin
        case ($urandom_range(9, 0))
          0:       pick_value = 0;
          1:       pick_value = 9'h1FF;
          2:       pick_value = STRIP_CAP;
          3:       pick_value = $urandom_range(9'h1FF, 0);
          default: pick_value = $urandom_range(12, 1);
        endcase
        write_reg(lseg_pkg::CFG_NUM_LEDS, pick_value, 9);
      end
      if ($urandom_range(3, 0) == 0)
        write_reg(lseg_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_HI, CFG_IDX_SPARE_LO)),
                  $urandom, 0);

      // Receiver holds off while the sender keeps offering
      if (phase == 8) hold_left = HOLD_CYCLES;

      count = (phase % 2 == 1) ? RAINBOW_ITEMS : OTHER_ITEMS;
      for (item = 0; item < count; item++) begin
        // Sender pauses mid-phase; a shorter strip may land under the scanner
        if (item == count / 2) begin
          wait_idle();
          if ($urandom_range(1, 0) != 0)
            write_reg(lseg_pkg::CFG_NUM_LEDS, $urandom_range(4, 1), 9);
        end
        send_stamp(next_stamp());
      end
    end

    wait_idle();
    if (errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
